@@ design/row_l2_normalize_defines.svh @@
// Assertion macros shared by the row normalizer modules.
// The enclosing module must have clk_i and rst_ni.
`ifndef ROW_L2_NORMALIZE_DEFINES_SVH
`define ROW_L2_NORMALIZE_DEFINES_SVH

`ifndef SYNTHESIS
`define RLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RLN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RLN_ASSERT(lbl, prop, msg)
`define RLN_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ design/rln_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rln_pkg;

  localparam int SCALE_W    = 40;
  localparam int SCALE_FRAC = 24;
  localparam int EPS_W      = 32;

  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } rsqrt_status_t;

endpackage

`default_nettype wire

@@ design/rln_rsqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "row_l2_normalize_defines.svh"

module rln_rsqrt #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ACC_WIDTH-1:0]          t_i,
  output rln_pkg::rsqrt_status_t             status_o,
  output logic      [rln_pkg::SCALE_W-1:0]   scale_o
);

  localparam int FW  = DATA_WIDTH - 1;
  localparam int QW  = 2 * rln_pkg::SCALE_FRAC + 2 * FW + 1;
  localparam int RW  = (QW + 1) / 2;
  localparam int QP  = 2 * RW;
  localparam int AW  = ACC_WIDTH;
  localparam int RMW = (AW > RW + 1) ? AW : RW + 1;
  localparam int SW  = RMW + 2;
  localparam int CW  = $clog2(QW + 1);
  localparam int RXW = (RW > rln_pkg::SCALE_W) ? RW : rln_pkg::SCALE_W;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_SQRT = 2'd2;

  logic [1:0]                  st_q, st_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        done_q, done_d;
  logic [AW-1:0]               t_q, t_d;
  logic [RMW-1:0]              rem_q, rem_d;
  logic [QP-1:0]               quo_q, quo_d;
  logic [RW-1:0]               root_q, root_d;
  logic [rln_pkg::SCALE_W-1:0] scale_q, scale_d;

  logic [SW-1:0]               div_a, sq_a, sq_b, op_a, op_b, diff, nxt_rem;
  logic                        take;
  logic [RW-1:0]               root_nxt;
  logic [RXW-1:0]              root_x;
  logic [rln_pkg::SCALE_W-1:0] scale_sat;

  // One compare and subtract serves both the long division and the root.
  assign div_a   = SW'({rem_q[AW-1:0], cnt_q == CW'(QW - 1)});
  assign sq_a    = SW'({rem_q[RW:0], quo_q[QP-1:QP-2]});
  assign sq_b    = SW'({root_q, 2'b01});
  assign op_a    = (st_q == R_DIV) ? div_a : sq_a;
  assign op_b    = (st_q == R_DIV) ? SW'(t_q) : sq_b;
  assign take    = op_a >= op_b;
  assign diff    = op_a - op_b;
  assign nxt_rem = take ? diff : op_a;

  assign root_nxt  = {root_q[RW-2:0], take};
  assign root_x    = RXW'(root_nxt);
  assign scale_sat = (root_x > RXW'(rln_pkg::SCALE_MAX)) ? rln_pkg::SCALE_MAX
                                                         : root_x[rln_pkg::SCALE_W-1:0];

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    t_d     = t_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    root_d  = root_q;
    scale_d = scale_q;
    case (st_q)
      R_IDLE: begin
        if (start_i) begin
          if (t_i == '0) begin
            scale_d = rln_pkg::SCALE_MAX;
            done_d  = 1'b1;
          end else begin
            t_d   = t_i;
            rem_d = '0;
            quo_d = '0;
            cnt_d = CW'(QW - 1);
            st_d  = R_DIV;
          end
        end
      end
      R_DIV: begin
        rem_d = nxt_rem[RMW-1:0];
        quo_d = {quo_q[QP-2:0], take};
        if (cnt_q == '0) begin
          st_d   = R_SQRT;
          cnt_d  = CW'(RW - 1);
          rem_d  = '0;
          root_d = '0;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      R_SQRT: begin
        rem_d  = nxt_rem[RMW-1:0];
        root_d = root_nxt;
        quo_d  = {quo_q[QP-3:0], 2'b00};
        if (cnt_q == '0) begin
          scale_d = scale_sat;
          done_d  = 1'b1;
          st_d    = R_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        st_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= R_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    root_q  <= root_d;
    scale_q <= scale_d;
  end

  assign status_o.busy = st_q != R_IDLE;
  assign status_o.done = done_q;
  assign scale_o       = scale_q;

  `RLN_ASSERT(a_zero_total, (start_i && (t_i == '0) && !status_o.busy) |=> (status_o.done && (scale_o == rln_pkg::SCALE_MAX)), "zero total did not give the largest scale")
  `RLN_ASSERT(a_busy_from_start, $rose(status_o.busy) |-> $past(start_i), "root unit became busy without a start")
  `RLN_ASSERT_RST(a_done_idle, status_o.done |-> !status_o.busy, "root unit reports done while busy")

endmodule

`default_nettype wire

@@ design/row_l2_normalize.sv @@
// Row L2 normalizer.
// Input stream: tdata carries one signed row element, tuser selects the pass
// (0 adds the element's square to the row sum, 1 requests a scaled result) and
// tlast marks the final element of the row in that pass. Only scale requests
// produce output; the result stream carries the saturated element times the
// row scale in tdata and a copy of tlast.
// The user must write the epsilon register with cfg_we_i only while no request
// is in flight; the block itself does not enforce it. s_axis_tready stays low
// while a request is in progress. An accumulate request passes through the
// multiply and accumulate steps; a scale request passes through two multiply
// steps and the output step, and its result is registered in the output
// register. On the last accumulate element the reciprocal square root of the
// row sum plus epsilon follows: a bit-serial divide to a QW-bit quotient,
// QW = 49 + 2*(DATA_WIDTH-1), then a bit-serial root; zero totals skip both.
// Reset clears the row sum and the row scale (results are zero until a row is
// accumulated) and sets epsilon to one. When the receiver stalls the result
// waits in the output register and the block still finishes the next request,
// holding only a second scale result until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "row_l2_normalize_defines.svh"

module row_l2_normalize #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rln_pkg::EPS_W-1:0]            cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // element
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // mode
  input  wire logic [0:0]                           s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // normalized
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0]     m_axis_tdata,
  output logic                                      m_axis_tlast
);

  localparam int DW  = DATA_WIDTH;
  localparam int AW  = ACC_WIDTH;
  localparam int TW  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int MBW = (DW > rln_pkg::SCALE_FRAC) ? DW : rln_pkg::SCALE_FRAC;
  localparam int MW  = DW + MBW;
  localparam int XW  = ((AW > 2 * DW) ? AW : 2 * DW) + 1;
  localparam int PW  = MW + 2;

  localparam logic [PW-1:0] SIGN_MAG = PW'(1) << (DW - 1);
  localparam logic [PW-1:0] POS_MAX  = SIGN_MAG - PW'(1);
  localparam logic [PW-1:0] HALF_LSB = PW'(1) << (rln_pkg::SCALE_FRAC - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_EPS  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                  st_q, st_d;
  logic                        mode_q, mode_d;
  logic                        neg_q, neg_d;
  logic                        last_q, last_d;
  logic [DW-1:0]               mag_q, mag_d;
  logic [MW-1:0]               mul_q, mul_d;
  logic [MW-1:0]               plo_q, plo_d;
  logic [AW-1:0]               sum_q, sum_d;
  logic [rln_pkg::SCALE_W-1:0] row_scale_q, row_scale_d;
  logic [rln_pkg::EPS_W-1:0]   eps_q;
  logic                        mvalid_q, mvalid_d;
  logic [DW-1:0]               mdata_q, mdata_d;
  logic                        mlast_q, mlast_d;

  logic                        accept;
  logic [DW-1:0]               raw;
  logic [MBW-1:0]              mul_b;
  logic [MW-1:0]               mul_p;
  logic [XW-1:0]               acc_s;
  logic [AW-1:0]               acc_sat;
  logic [AW:0]                 t_s;
  logic [AW-1:0]               t_sat;
  logic [PW-1:0]               rnd, prod, clamp;
  logic [DW-1:0]               res;
  logic                        rs_start;
  rln_pkg::rsqrt_status_t      rs_status;
  logic [rln_pkg::SCALE_W-1:0] rs_scale;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign raw    = s_axis_tdata[DW-1:0];

  // Shared multiplier: square for accumulate, low then high scale part for scale.
  always_comb begin
    if (st_q == S_MUL2) begin
      mul_b = MBW'(row_scale_q[rln_pkg::SCALE_W-1:rln_pkg::SCALE_FRAC]);
    end else if (mode_q) begin
      mul_b = MBW'(row_scale_q[rln_pkg::SCALE_FRAC-1:0]);
    end else begin
      mul_b = MBW'(mag_q);
    end
  end
  assign mul_p = MW'(mag_q) * MW'(mul_b);

  assign acc_s   = XW'(sum_q) + XW'(mul_q[2*DW-1:0]);
  assign acc_sat = (acc_s > XW'({AW{1'b1}})) ? {AW{1'b1}} : acc_s[AW-1:0];
  assign t_s     = (AW + 1)'(sum_q) + (AW + 1)'(eps_q);
  assign t_sat   = t_s[AW] ? {AW{1'b1}} : t_s[AW-1:0];

  assign rnd  = PW'(plo_q) + HALF_LSB;
  assign prod = PW'(mul_q) + (rnd >> rln_pkg::SCALE_FRAC);
  always_comb begin
    if (neg_q) begin
      clamp = (prod > SIGN_MAG) ? SIGN_MAG : prod;
      res   = ~clamp[DW-1:0] + 1'b1;
    end else begin
      clamp = (prod > POS_MAX) ? POS_MAX : prod;
      res   = clamp[DW-1:0];
    end
  end

  assign rs_start = st_q == S_EPS;

  rln_rsqrt #(
    .DATA_WIDTH(DATA_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rs_start),
    .t_i     (t_sat),
    .status_o(rs_status),
    .scale_o (rs_scale)
  );

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    neg_d       = neg_q;
    last_d      = last_q;
    mag_d       = mag_q;
    mul_d       = mul_q;
    plo_d       = plo_q;
    sum_d       = sum_q;
    row_scale_d = row_scale_q;
    mvalid_d    = mvalid_q;
    mdata_d     = mdata_q;
    mlast_d     = mlast_q;
    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = s_axis_tuser[0];
          last_d = s_axis_tlast;
          neg_d  = raw[DW-1];
          mag_d  = raw[DW-1] ? (~raw + 1'b1) : raw;
          st_d   = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_d = mul_p;
        st_d  = mode_q ? S_MUL2 : S_ACC;
      end
      S_MUL2: begin
        plo_d = mul_q;
        mul_d = mul_p;
        st_d  = S_OUT;
      end
      S_ACC: begin
        sum_d = acc_sat;
        st_d  = last_q ? S_EPS : S_IDLE;
      end
      S_EPS: begin
        sum_d = '0;
        st_d  = S_ROOT;
      end
      S_ROOT: begin
        if (rs_status.done) begin
          row_scale_d = rs_scale;
          st_d        = S_IDLE;
        end
      end
      S_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = res;
          mlast_d  = last_q;
          st_d     = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      sum_q       <= '0;
      row_scale_q <= '0;
      eps_q       <= rln_pkg::EPS_W'(1);
      mvalid_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      sum_q       <= sum_d;
      row_scale_q <= row_scale_d;
      mvalid_q    <= mvalid_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    neg_q   <= neg_d;
    last_q  <= last_d;
    mag_q   <= mag_d;
    mul_q   <= mul_d;
    plo_q   <= plo_d;
    mdata_q <= mdata_d;
    mlast_q <= mlast_d;
  end

  assign s_axis_tready = st_q == S_IDLE;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = TW'(mdata_q);
  assign m_axis_tlast  = mlast_q;

  `RLN_ASSERT(a_busy_after_req, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input ready right after a request")
  `RLN_ASSERT(a_start_idle, rs_start |-> !rs_status.busy, "root started while busy")
  `RLN_ASSERT(a_scale_from_root, !$stable(row_scale_q) |-> $past(rs_status.done), "row scale changed without a root result")
  `RLN_ASSERT(a_out_from_seq, $rose(m_axis_tvalid) |-> $past(st_q == S_OUT), "result appeared outside the output step")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int DW            = 16;
  localparam int ACC_W         = 48;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_PRINTS    = 200;

  typedef enum bit {
    MODE_ACCUM = 1'b0,
    MODE_SCALE = 1'b1
  } norm_mode_e;

  typedef struct {
    bit                        is_cfg;
    norm_mode_e                mode;
    logic [DW-1:0]             element;
    bit                        last;
    logic [rln_pkg::EPS_W-1:0] eps;
  } norm_req_t;

  typedef struct {
    logic [DW-1:0] value;
    bit            last;
  } norm_result_t;

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_we_i      = 1'b0;
  logic [rln_pkg::EPS_W-1:0]            cfg_wdata_i   = '0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [DW-1:0]                        s_axis_tdata  = '0;
  logic [0:0]                           s_axis_tuser  = '0;
  logic                                 s_axis_tlast  = 1'b0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [DW-1:0]                        m_axis_tdata;
  logic                                 m_axis_tlast;

  norm_req_t                   pending_req[$];
  norm_result_t                expected_norm[$];
  logic [ACC_W-1:0]            sum_sq       = '0;
  logic [rln_pkg::SCALE_W-1:0] row_scale    = '0;
  logic [rln_pkg::EPS_W-1:0]   eps_q30      = 32'd1;
  int                          mismatches   = 0;
  int                          settle_cnt   = 0;
  int                          burst_left   = 1;
  int                          gap_left     = 0;
  int                          stall_left   = 0;
  int                          rx_phase     = 0;

  row_l2_normalize #(
    .DATA_WIDTH(DW),
    .ACC_WIDTH (ACC_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ACC_W-1:0] sat_add_acc(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  // Scale = floor(2^24 / sqrt(t * 2^-30)) = floor(sqrt(2^78 / t)).
  function automatic logic [rln_pkg::SCALE_W-1:0] recip_root_scale(logic [ACC_W-1:0] t);
    logic [127:0] quot;
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] trial;
    if (t == '0) return rln_pkg::SCALE_MAX;
    quot = (128'd1 << 78) / {80'd0, t};
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | ((quot >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    if (root > {88'd0, rln_pkg::SCALE_MAX}) return rln_pkg::SCALE_MAX;
    return root[rln_pkg::SCALE_W-1:0];
  endfunction

  task automatic predict_request(norm_req_t r);
    logic [DW-1:0] mag;
    logic [63:0]   prod;
    bit            neg;
    norm_result_t  res;
    neg = r.element[DW-1];
    mag = neg ? (~r.element + 16'd1) : r.element;
    if (r.mode == MODE_ACCUM) begin
      sum_sq = sat_add_acc(sum_sq, {32'd0, mag} * {32'd0, mag});
      if (r.last) begin
        row_scale = recip_root_scale(sat_add_acc(sum_sq, {16'd0, eps_q30}));
        sum_sq    = '0;
      end
    end else begin
      prod = ({48'd0, mag} * {24'd0, row_scale} + (64'd1 << 23)) >> 24;
      if (neg) begin
        if (prod > 64'd32768) prod = 64'd32768;
        res.value = ~prod[DW-1:0] + 16'd1;
      end else begin
        if (prod > 64'd32767) prod = 64'd32767;
        res.value = prod[DW-1:0];
      end
      res.last = r.last;
      expected_norm.push_back(res);
    end
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_elem(norm_mode_e mode, logic [DW-1:0] element, bit last);
    norm_req_t r;
    r.is_cfg  = 1'b0;
    r.mode    = mode;
    r.element = element;
    r.last    = last;
    r.eps     = '0;
    pending_req.push_back(r);
  endtask

  task automatic push_eps(logic [rln_pkg::EPS_W-1:0] value);
    norm_req_t r;
    r.is_cfg  = 1'b1;
    r.mode    = MODE_ACCUM;
    r.element = '0;
    r.last    = 1'b0;
    r.eps     = value;
    pending_req.push_back(r);
  endtask

  function automatic logic [DW-1:0] pick_element(int style);
    case (style)
      0: return '0;
      1: return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // One row: an accumulate pass and then a scale pass, with occasional noise
  // and broken passes that leave a partial sum or drop the row end marker.
  task automatic push_row(ref int count);
    logic [DW-1:0] row[$];
    int            len;
    int            style;
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
    style = $urandom_range(0, 9);
    if ($urandom_range(0, 9) == 0) begin
      push_elem(norm_mode_e'($urandom_range(0, 1)), 16'($urandom), bit'($urandom_range(0, 1)));
      count++;
      return;
    end
    for (int i = 0; i < len; i++) row.push_back(pick_element(style));
    for (int i = 0; i < len; i++) begin
      push_elem(MODE_ACCUM, row[i], (i == len - 1) && ($urandom_range(0, 9) != 0));
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) row[i] = 16'($urandom);
      push_elem(MODE_SCALE, row[i], (i == len - 1) && ($urandom_range(0, 7) != 0));
    end
    count += 2 * len;
  endtask

  always @(posedge clk_i) begin
    bit took;
    bit nvalid;
    bit nwe;
    if (rst_ni) begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        predict_request(pending_req[0]);
        pending_req.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (expected_norm.size() == 0 && !s_axis_tvalid) settle_cnt++;
      else settle_cnt = 0;
      nvalid = 1'b0;
      nwe    = 1'b0;
      if (s_axis_tvalid && !took) begin
        nvalid = 1'b1;
      end else if (pending_req.size() > 0) begin
        if (pending_req[0].is_cfg) begin
          if (settle_cnt >= SETTLE_CYCLES) begin
            nwe         = 1'b1;
            eps_q30     = pending_req[0].eps;
            cfg_wdata_i <= pending_req[0].eps;
            pending_req.pop_front();
            settle_cnt  = 0;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          nvalid = 1'b1;
          s_axis_tdata <= pending_req[0].element;
          s_axis_tuser <= pending_req[0].mode;
          s_axis_tlast <= pending_req[0].last;
        end
      end
      s_axis_tvalid <= nvalid;
      cfg_we_i      <= nwe;
    end
  end

  always @(posedge clk_i) begin
    norm_result_t exp_res;
    bit           nready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_norm.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          exp_res = expected_norm.pop_front();
          if (m_axis_tdata !== exp_res.value || m_axis_tlast !== exp_res.last) begin
            report_mismatch($sformatf("normalized %h last %b, expected %h last %b",
                                      m_axis_tdata, m_axis_tlast, exp_res.value, exp_res.last));
          end
        end
      end
      rx_phase = (rx_phase + 1) % 256;
      if (stall_left > 0) begin
        stall_left--;
        nready = 1'b0;
      end else if (rx_phase < 64) begin
        nready = 1'b1;
      end else if (rx_phase < 128) begin
        nready = bit'($urandom_range(0, 1));
      end else begin
        nready = 1'b1;
        if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 40);
          nready     = 1'b0;
        end
      end
      m_axis_tready <= nready;
    end
  end

  initial begin
    logic [rln_pkg::EPS_W-1:0] phase_eps[8];
    int                        count;
    // Scale requests before any row see a zero scale.
    push_elem(MODE_SCALE, 16'h7FFF, 1'b0);
    push_elem(MODE_SCALE, 16'h8000, 1'b0);
    push_elem(MODE_SCALE, 16'h0000, 1'b1);
    push_elem(MODE_ACCUM, 16'h8000, 1'b0);
    push_elem(MODE_ACCUM, 16'h7FFF, 1'b1);
    push_elem(MODE_SCALE, 16'h8000, 1'b0);
    push_elem(MODE_SCALE, 16'h7FFF, 1'b0);
    push_elem(MODE_SCALE, 16'hFFFF, 1'b0);
    push_elem(MODE_SCALE, 16'h0001, 1'b1);
    // A zero total with no epsilon saturates the scale.
    push_eps(32'd0);
    push_elem(MODE_ACCUM, 16'h0000, 1'b1);
    push_elem(MODE_SCALE, 16'h7FFF, 1'b0);
    push_elem(MODE_SCALE, 16'h8000, 1'b0);
    push_elem(MODE_SCALE, 16'h0001, 1'b0);
    push_elem(MODE_SCALE, 16'hFFFF, 1'b0);
    push_elem(MODE_SCALE, 16'h0000, 1'b1);
    push_eps(32'hFFFF_FFFF);
    push_elem(MODE_ACCUM, 16'h0000, 1'b0);
    push_elem(MODE_ACCUM, 16'h8000, 1'b1);
    push_elem(MODE_SCALE, 16'h8000, 1'b0);
    push_elem(MODE_SCALE, 16'h7FFF, 1'b1);

    phase_eps[0] = 32'd1;
    phase_eps[1] = 32'd0;
    phase_eps[2] = 32'hFFFF_FFFF;
    phase_eps[3] = $urandom;
    phase_eps[4] = 32'd1 << $urandom_range(0, 31);
    phase_eps[5] = $urandom_range(0, 1023);
    phase_eps[6] = 32'h4000_0000;
    phase_eps[7] = $urandom;
    for (int p = 0; p < 8; p++) begin
      push_eps(phase_eps[p]);
      count = 0;
      while (count < 200) push_row(count);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_req.size() == 0 && !s_axis_tvalid);
    wait (expected_norm.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_norm.size() != 0) report_mismatch("results still expected at end of run");
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TIMEOUT");
    $display("tb_top: errors");
    $finish;
  end

endmodule
